// ===== design/lcg_parameter_recovery_defines.svh =====
// Assertion macros shared by the LCG parameter recovery RTL.
// Expects clk and rst_n in the scope where a macro is used; no other dependencies.
`ifndef LCG_PARAMETER_RECOVERY_DEFINES_SVH
`define LCG_PARAMETER_RECOVERY_DEFINES_SVH
`ifndef SYNTHESIS
`define LCGPR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcgpr: implication check failed");
`define LCGPR_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcgpr: next-cycle check failed");
`define LCGPR_ASSERT_DLY(label, ante, n, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error("lcgpr: latency check failed");
`else
`define LCGPR_ASSERT_IMP(label, ante, cons)
`define LCGPR_ASSERT_NXT(label, ante, cons)
`define LCGPR_ASSERT_DLY(label, ante, n, cons)
`endif
`endif

// ===== design/lcgpr_pkg.sv =====
// Shared types, constants and helpers for the LCG parameter recovery block.
// No dependencies.
package lcgpr_pkg;

    localparam int unsigned FIELD_BITS        = 32;
    localparam int unsigned WORD_BITS_DEFAULT = 32;

    // Control travelling alongside each beat down the pipe
    typedef struct packed {
        logic valid;
        logic missing;
    } lane_ctrl_t;

    // Newton steps needed: start value is good to 3 bits, each step doubles that
    function automatic int unsigned newton_steps(input int unsigned w);
        int unsigned n;
        int unsigned b;
        int          i;
        n = 0;
        b = 3;
        for (i = 0; i < 8; i++)
        begin
            if (b < w)
            begin
                b = b * 2;
                n = n + 1;
            end
        end
        return n;
    endfunction

endpackage

// ===== design/lcgpr_newton_cell.sv =====
// One Newton refinement cell for the odd inverse: x' = x * (2 - v * x).
// Two register stages; carries the beat's payload along. Uses lcgpr_pkg.
module lcgpr_newton_cell
    import lcgpr_pkg::*;
#(
    parameter int unsigned WORD_BITS = WORD_BITS_DEFAULT
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lane_ctrl_t           up_ctrl,
    input  logic [WORD_BITS-1:0] up_v,
    input  logic [WORD_BITS-1:0] up_x,
    input  logic [WORD_BITS-1:0] up_s1,
    input  logic [WORD_BITS-1:0] up_s2,
    input  logic [WORD_BITS-1:0] up_d1,
    output lane_ctrl_t           dn_ctrl,
    output logic [WORD_BITS-1:0] dn_v,
    output logic [WORD_BITS-1:0] dn_x,
    output logic [WORD_BITS-1:0] dn_s1,
    output logic [WORD_BITS-1:0] dn_s2,
    output logic [WORD_BITS-1:0] dn_d1
);

    localparam logic [WORD_BITS-1:0] TWO = WORD_BITS'(2);

    lane_ctrl_t           ctrl_a_reg, ctrl_b_reg;
    logic [WORD_BITS-1:0] v_a_reg, x_a_reg, t_a_reg, s1_a_reg, s2_a_reg, d1_a_reg;
    logic [WORD_BITS-1:0] v_b_reg, x_b_reg, s1_b_reg, s2_b_reg, d1_b_reg;
    logic [WORD_BITS-1:0] t_a_next, x_b_next;

    assign t_a_next = up_v * up_x;
    assign x_b_next = x_a_reg * (TWO - t_a_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_a_reg <= '0;
            ctrl_b_reg <= '0;
        end
        else
        begin
            ctrl_a_reg <= up_ctrl;
            ctrl_b_reg <= ctrl_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        v_a_reg  <= up_v;
        x_a_reg  <= up_x;
        t_a_reg  <= t_a_next;
        s1_a_reg <= up_s1;
        s2_a_reg <= up_s2;
        d1_a_reg <= up_d1;
        v_b_reg  <= v_a_reg;
        x_b_reg  <= x_b_next;
        s1_b_reg <= s1_a_reg;
        s2_b_reg <= s2_a_reg;
        d1_b_reg <= d1_a_reg;
    end

    assign dn_ctrl = ctrl_b_reg;
    assign dn_v    = v_b_reg;
    assign dn_x    = x_b_reg;
    assign dn_s1   = s1_b_reg;
    assign dn_s2   = s2_b_reg;
    assign dn_d1   = d1_b_reg;

endmodule

// ===== design/lcgpr_tail.sv =====
// Final stages: multiplier = d1 * inverse, then increment = s2 - s1 * multiplier.
// Uses lcgpr_pkg and the assertion macros header.
`include "lcg_parameter_recovery_defines.svh"
module lcgpr_tail
    import lcgpr_pkg::*;
#(
    parameter int unsigned WORD_BITS = WORD_BITS_DEFAULT
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lane_ctrl_t           up_ctrl,
    input  logic [WORD_BITS-1:0] up_v,
    input  logic [WORD_BITS-1:0] up_x,
    input  logic [WORD_BITS-1:0] up_s1,
    input  logic [WORD_BITS-1:0] up_s2,
    input  logic [WORD_BITS-1:0] up_d1,
    output lane_ctrl_t           res_ctrl,
    output logic [WORD_BITS-1:0] res_mult,
    output logic [WORD_BITS-1:0] res_incr
);

    localparam logic [WORD_BITS-1:0] ONE = WORD_BITS'(1);

    lane_ctrl_t           mid_ctrl_reg, res_ctrl_reg;
    logic [WORD_BITS-1:0] mult_reg, s1_reg, s2_reg;
    logic [WORD_BITS-1:0] res_mult_reg, res_incr_reg;
    logic [WORD_BITS-1:0] inv, mult_next, incr_next;

    // even difference has no inverse: fall back to 1
    assign inv       = up_ctrl.missing ? ONE : up_x;
    assign mult_next = up_d1 * inv;
    assign incr_next = s2_reg - s1_reg * mult_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_ctrl_reg <= '0;
            res_ctrl_reg <= '0;
        end
        else
        begin
            mid_ctrl_reg <= up_ctrl;
            res_ctrl_reg <= mid_ctrl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mult_reg     <= mult_next;
        s1_reg       <= up_s1;
        s2_reg       <= up_s2;
        res_mult_reg <= mult_reg;
        res_incr_reg <= incr_next;
    end

    assign res_ctrl = res_ctrl_reg;
    assign res_mult = res_mult_reg;
    assign res_incr = res_incr_reg;

    `LCGPR_ASSERT_IMP(a_inverse_ok, up_ctrl.valid && !up_ctrl.missing, WORD_BITS'(up_v * up_x) == ONE)
    `LCGPR_ASSERT_IMP(a_missing_flag, up_ctrl.valid, up_ctrl.missing == !up_v[0])
    `LCGPR_ASSERT_NXT(a_fallback, up_ctrl.valid && up_ctrl.missing, mult_reg == $past(up_d1))

endmodule

// ===== design/lcg_parameter_recovery.sv =====
// Top level of the LCG parameter recovery block: input stage, row of Newton cells, tail.
// Uses lcgpr_pkg, lcgpr_newton_cell, lcgpr_tail and the assertion macros header.
//
// Usage:
//   Drive first_output, second_output and third_output (three consecutive
//   generator outputs) and pulse start; a beat is taken on every edge where
//   start is high and busy is low. busy is always low, so a new triple can be
//   taken every cycle.
//   Each beat yields one result: multiplier, increment and no_inverse appear
//   together with done for exactly one cycle. no_inverse is set when
//   first_output - second_output is even; the inverse is then taken as 1.
//   A beat passes from the input register through N Newton cells and the
//   tail to done, with N the number of Newton cells (N = 4 at 32 bits).
//   Each cell costs two multiply stages; the tail adds two more stages.
//   Throughput is one triple per cycle; results leave in input order.
//   Reset clears every valid bit in the pipe, so no result appears for a
//   beat in flight at reset. The receiver has no back-pressure and must take
//   each result in the cycle that done is high.
`include "lcg_parameter_recovery_defines.svh"
module lcg_parameter_recovery
    import lcgpr_pkg::*;
#(
    parameter int unsigned WORD_BITS = WORD_BITS_DEFAULT
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [FIELD_BITS-1:0] first_output,
    input  logic [FIELD_BITS-1:0] second_output,
    input  logic [FIELD_BITS-1:0] third_output,
    output logic                  done,
    output logic [FIELD_BITS-1:0] multiplier,
    output logic [FIELD_BITS-1:0] increment,
    output logic                  no_inverse
);

    localparam int unsigned STEPS = newton_steps(WORD_BITS);
    localparam int unsigned LAT   = 2 * STEPS + 3;

    lane_ctrl_t           in_ctrl_reg, in_ctrl_next;
    logic [WORD_BITS-1:0] s1_reg, s2_reg, d0_reg, d1_reg;
    logic [WORD_BITS-1:0] s1_next, s2_next, s3_next, d0_next, d1_next;

    lane_ctrl_t           ctrl_chain [0:STEPS];
    logic [WORD_BITS-1:0] v_chain    [0:STEPS];
    logic [WORD_BITS-1:0] x_chain    [0:STEPS];
    logic [WORD_BITS-1:0] s1_chain   [0:STEPS];
    logic [WORD_BITS-1:0] s2_chain   [0:STEPS];
    logic [WORD_BITS-1:0] d1_chain   [0:STEPS];

    lane_ctrl_t           res_ctrl;
    logic [WORD_BITS-1:0] res_mult, res_incr;
    logic                 accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign s1_next = WORD_BITS'(first_output);
    assign s2_next = WORD_BITS'(second_output);
    assign s3_next = WORD_BITS'(third_output);
    assign d0_next = s1_next - s2_next;
    assign d1_next = s2_next - s3_next;

    assign in_ctrl_next.valid   = accept;
    assign in_ctrl_next.missing = ~d0_next[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ctrl_reg <= '0;
        end
        else
        begin
            in_ctrl_reg <= in_ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        s2_reg <= s2_next;
        d0_reg <= d0_next;
        d1_reg <= d1_next;
    end

    // Newton seed is d0 itself (good to 3 bits for odd d0)
    assign ctrl_chain[0] = in_ctrl_reg;
    assign v_chain[0]    = d0_reg;
    assign x_chain[0]    = d0_reg;
    assign s1_chain[0]   = s1_reg;
    assign s2_chain[0]   = s2_reg;
    assign d1_chain[0]   = d1_reg;

    for (genvar g = 0; g < STEPS; g++)
    begin : g_cell
        lcgpr_newton_cell #(
            .WORD_BITS (WORD_BITS)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .up_ctrl (ctrl_chain[g]),
            .up_v    (v_chain[g]),
            .up_x    (x_chain[g]),
            .up_s1   (s1_chain[g]),
            .up_s2   (s2_chain[g]),
            .up_d1   (d1_chain[g]),
            .dn_ctrl (ctrl_chain[g+1]),
            .dn_v    (v_chain[g+1]),
            .dn_x    (x_chain[g+1]),
            .dn_s1   (s1_chain[g+1]),
            .dn_s2   (s2_chain[g+1]),
            .dn_d1   (d1_chain[g+1])
        );
    end

    lcgpr_tail #(
        .WORD_BITS (WORD_BITS)
    ) u_tail (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_ctrl  (ctrl_chain[STEPS]),
        .up_v     (v_chain[STEPS]),
        .up_x     (x_chain[STEPS]),
        .up_s1    (s1_chain[STEPS]),
        .up_s2    (s2_chain[STEPS]),
        .up_d1    (d1_chain[STEPS]),
        .res_ctrl (res_ctrl),
        .res_mult (res_mult),
        .res_incr (res_incr)
    );

    assign done       = res_ctrl.valid;
    assign no_inverse = res_ctrl.missing;
    assign multiplier = FIELD_BITS'(res_mult);
    assign increment  = FIELD_BITS'(res_incr);

    `LCGPR_ASSERT_DLY(a_latency, accept, LAT, done)
    `LCGPR_ASSERT_IMP(a_no_orphan, done, $past(accept, LAT))

endmodule
